// File: design/tun_pkg.sv
package tun_pkg;

    localparam int COORD_BITS       = 16;
    localparam int NORMAL_FRAC_BITS = 15;
    localparam int OUT_W            = NORMAL_FRAC_BITS + 1;

    localparam int EDGE_W    = COORD_BITS + 1;
    localparam int PROD_W    = 2 * EDGE_W;
    localparam int CROSS_W   = PROD_W + 1;
    localparam int MAG_W     = CROSS_W - 1;
    localparam int HALF_W    = (MAG_W + 1) / 2;
    localparam int HIGH_W    = MAG_W - HALF_W;
    localparam int SQ_W      = 2 * MAG_W;
    localparam int S_W       = SQ_W + 2;
    localparam int RHS_SHIFT = 2 * NORMAL_FRAC_BITS + 2;
    localparam int ACC_W     = S_W + 2 * NORMAL_FRAC_BITS + 6;
    localparam int NUM_ITER  = NORMAL_FRAC_BITS + 1;

    localparam int ZLIM_W     = 32;
    localparam int AREA_W     = 34;
    localparam int AREA_LO_W  = (AREA_W + 1) / 2;
    localparam int AREA_HI_W  = AREA_W - AREA_LO_W;
    localparam int AREA_SQ_W  = 2 * AREA_W;
    localparam int CFG_W      = 34;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_AREA   = 2'd1;

    localparam logic [ZLIM_W-1:0] ZLIM_RESET = 32'd0;
    localparam logic [AREA_W-1:0] AREA_RESET = 34'd66;

    localparam logic [OUT_W-1:0] MAX_Q = OUT_W'((1 << NORMAL_FRAC_BITS) - 1);

    typedef struct packed {
        logic signed [COORD_BITS-1:0] v0_x;
        logic signed [COORD_BITS-1:0] v0_y;
        logic signed [COORD_BITS-1:0] v0_z;
        logic signed [COORD_BITS-1:0] v1_x;
        logic signed [COORD_BITS-1:0] v1_y;
        logic signed [COORD_BITS-1:0] v1_z;
        logic signed [COORD_BITS-1:0] v2_x;
        logic signed [COORD_BITS-1:0] v2_y;
        logic signed [COORD_BITS-1:0] v2_z;
    } t_tri_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] normal_x;
        logic signed [OUT_W-1:0] normal_y;
        logic signed [OUT_W-1:0] normal_z;
        logic                    area_ok;
    } t_tri_out;

endpackage

// File: design/triangle_unit_normal_top.sv
// Throughput: one triangle per cycle unless the output stalls; seven
// arithmetic stages, then one stage per normal bit of the
// shift-and-subtract square-root division. A stall at the output holds
// every stage together. Reset clears the stage valid bits and loads the
// register defaults.
module triangle_unit_normal_top import tun_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_tri_in              i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_tri_out             o_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic w_en;

    logic [ZLIM_W-1:0]            r_zero_limit;
    logic [AREA_W-1:0]            r_min_area;
    logic [2*AREA_HI_W-1:0]       r_area_hh;
    logic [AREA_HI_W+AREA_LO_W-1:0] r_area_hl;
    logic [2*AREA_LO_W-1:0]       r_area_ll;
    logic [AREA_SQ_W-1:0]         r_area_sq;

    logic                     r1_valid;
    logic signed [EDGE_W-1:0] r1_e1 [3];
    logic signed [EDGE_W-1:0] r1_e2 [3];

    logic                     r2_valid;
    logic signed [PROD_W-1:0] r2_p [6];

    logic                      r3_valid;
    logic signed [CROSS_W-1:0] r3_c [3];

    logic [MAG_W-1:0]           w_mag [3];
    logic                       r4_valid;
    logic                       r4_neg [3];
    logic [2*HIGH_W-1:0]        r4_hh [3];
    logic [HIGH_W+HALF_W-1:0]   r4_hl [3];
    logic [2*HALF_W-1:0]        r4_ll [3];

    logic             r5_valid;
    logic             r5_neg [3];
    logic [SQ_W-1:0]  r5_sq [3];

    logic             r6_valid;
    logic             r6_neg [3];
    logic [SQ_W-1:0]  r6_sq [3];
    logic [S_W-1:0]   r6_s;

    logic                    w_zero;
    logic signed [ACC_W-1:0] w_s_ext;

    logic                    r_it_valid [NUM_ITER+1];
    logic                    r_it_zero  [NUM_ITER+1];
    logic                    r_it_ok    [NUM_ITER+1];
    logic [S_W-1:0]          r_it_s     [NUM_ITER+1];
    logic                    r_it_neg   [NUM_ITER+1][3];
    logic signed [ACC_W-1:0] r_it_r     [NUM_ITER+1][3];
    logic signed [ACC_W-1:0] r_it_a     [NUM_ITER+1][3];
    logic [OUT_W-1:0]        r_it_q     [NUM_ITER+1][3];

    logic signed [ACC_W-1:0] n_it_r [NUM_ITER][3];
    logic signed [ACC_W-1:0] n_it_a [NUM_ITER][3];
    logic [OUT_W-1:0]        n_it_q [NUM_ITER][3];

    logic [OUT_W-1:0] w_norm [3];

    logic     r_out_valid;
    t_tri_out r_out;

    assign w_en    = !r_out_valid || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_limit <= ZLIM_RESET;
            r_min_area   <= AREA_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_ZERO_LIMIT) begin
                r_zero_limit <= i_cfg_data[ZLIM_W-1:0];
            end else if (i_cfg_idx == CFG_MIN_AREA) begin
                r_min_area <= i_cfg_data[AREA_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_area_hh <= r_min_area[AREA_W-1:AREA_LO_W] * r_min_area[AREA_W-1:AREA_LO_W];
        r_area_hl <= r_min_area[AREA_W-1:AREA_LO_W] * r_min_area[AREA_LO_W-1:0];
        r_area_ll <= r_min_area[AREA_LO_W-1:0] * r_min_area[AREA_LO_W-1:0];
        r_area_sq <= (AREA_SQ_W'(r_area_hh) << (2 * AREA_LO_W))
                   + (AREA_SQ_W'(r_area_hl) << (AREA_LO_W + 1))
                   + AREA_SQ_W'(r_area_ll);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r4_valid    <= 1'b0;
            r5_valid    <= 1'b0;
            r6_valid    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k <= NUM_ITER; k++) begin
                r_it_valid[k] <= 1'b0;
            end
        end else if (w_en) begin
            r1_valid      <= i_valid;
            r2_valid      <= r1_valid;
            r3_valid      <= r2_valid;
            r4_valid      <= r3_valid;
            r5_valid      <= r4_valid;
            r6_valid      <= r5_valid;
            r_it_valid[0] <= r6_valid;
            for (int k = 1; k <= NUM_ITER; k++) begin
                r_it_valid[k] <= r_it_valid[k-1];
            end
            r_out_valid   <= r_it_valid[NUM_ITER];
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_mag[i] = r3_c[i][CROSS_W-1] ? MAG_W'(-r3_c[i]) : MAG_W'(r3_c[i]);
        end
    end

    assign w_zero  = r6_s <= S_W'(r_zero_limit);
    assign w_s_ext = $signed(ACC_W'(r6_s));

    always_comb begin
        logic signed [ACC_W-1:0] v_s;
        logic signed [ACC_W-1:0] v_d;
        for (int k = 0; k < NUM_ITER; k++) begin
            v_s = $signed(ACC_W'(r_it_s[k]));
            for (int i = 0; i < 3; i++) begin
                v_d = (r_it_a[k][i] <<< (NORMAL_FRAC_BITS - k + 2))
                    + (v_s <<< (2 * (NORMAL_FRAC_BITS - k) + 2));
                if (v_d <= r_it_r[k][i]) begin
                    n_it_r[k][i] = r_it_r[k][i] - v_d;
                    n_it_a[k][i] = r_it_a[k][i] + (v_s <<< (NORMAL_FRAC_BITS - k + 1));
                    n_it_q[k][i] = r_it_q[k][i] | (OUT_W'(1) << (NORMAL_FRAC_BITS - k));
                end else begin
                    n_it_r[k][i] = r_it_r[k][i];
                    n_it_a[k][i] = r_it_a[k][i];
                    n_it_q[k][i] = r_it_q[k][i];
                end
            end
        end
    end

    always_comb begin
        logic [OUT_W-1:0] v_sat;
        for (int i = 0; i < 3; i++) begin
            v_sat = (r_it_q[NUM_ITER][i] > MAX_Q) ? MAX_Q : r_it_q[NUM_ITER][i];
            if (r_it_zero[NUM_ITER]) begin
                w_norm[i] = '0;
            end else if (r_it_neg[NUM_ITER][i]) begin
                w_norm[i] = -v_sat;
            end else begin
                w_norm[i] = v_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_e1[0] <= EDGE_W'(i_data.v1_x) - EDGE_W'(i_data.v0_x);
            r1_e1[1] <= EDGE_W'(i_data.v1_y) - EDGE_W'(i_data.v0_y);
            r1_e1[2] <= EDGE_W'(i_data.v1_z) - EDGE_W'(i_data.v0_z);
            r1_e2[0] <= EDGE_W'(i_data.v2_x) - EDGE_W'(i_data.v0_x);
            r1_e2[1] <= EDGE_W'(i_data.v2_y) - EDGE_W'(i_data.v0_y);
            r1_e2[2] <= EDGE_W'(i_data.v2_z) - EDGE_W'(i_data.v0_z);

            r2_p[0] <= r1_e1[1] * r1_e2[2];
            r2_p[1] <= r1_e1[2] * r1_e2[1];
            r2_p[2] <= r1_e1[2] * r1_e2[0];
            r2_p[3] <= r1_e1[0] * r1_e2[2];
            r2_p[4] <= r1_e1[0] * r1_e2[1];
            r2_p[5] <= r1_e1[1] * r1_e2[0];

            for (int i = 0; i < 3; i++) begin
                r3_c[i] <= CROSS_W'(r2_p[2*i]) - CROSS_W'(r2_p[2*i+1]);

                r4_neg[i] <= r3_c[i][CROSS_W-1];
                r4_hh[i]  <= w_mag[i][MAG_W-1:HALF_W] * w_mag[i][MAG_W-1:HALF_W];
                r4_hl[i]  <= w_mag[i][MAG_W-1:HALF_W] * w_mag[i][HALF_W-1:0];
                r4_ll[i]  <= w_mag[i][HALF_W-1:0] * w_mag[i][HALF_W-1:0];

                r5_neg[i] <= r4_neg[i];
                r5_sq[i]  <= (SQ_W'(r4_hh[i]) << (2 * HALF_W))
                           + (SQ_W'(r4_hl[i]) << (HALF_W + 1))
                           + SQ_W'(r4_ll[i]);

                r6_neg[i] <= r5_neg[i];
                r6_sq[i]  <= r5_sq[i];

                r_it_neg[0][i] <= r6_neg[i];
                r_it_r[0][i]   <= $signed(ACC_W'(r6_sq[i]) << RHS_SHIFT) - w_s_ext;
                r_it_a[0][i]   <= -w_s_ext;
                r_it_q[0][i]   <= '0;
            end
            r6_s <= S_W'(r5_sq[0]) + S_W'(r5_sq[1]) + S_W'(r5_sq[2]);

            r_it_s[0]    <= r6_s;
            r_it_zero[0] <= w_zero;
            r_it_ok[0]   <= w_zero ? (r_min_area == '0) : (r6_s >= S_W'(r_area_sq));

            for (int k = 1; k <= NUM_ITER; k++) begin
                r_it_s[k]    <= r_it_s[k-1];
                r_it_zero[k] <= r_it_zero[k-1];
                r_it_ok[k]   <= r_it_ok[k-1];
                for (int i = 0; i < 3; i++) begin
                    r_it_neg[k][i] <= r_it_neg[k-1][i];
                    r_it_r[k][i]   <= n_it_r[k-1][i];
                    r_it_a[k][i]   <= n_it_a[k-1][i];
                    r_it_q[k][i]   <= n_it_q[k-1][i];
                end
            end

            r_out.normal_x <= w_norm[0];
            r_out.normal_y <= w_norm[1];
            r_out.normal_z <= w_norm[2];
            r_out.area_ok  <= r_it_ok[NUM_ITER];
        end
    end

endmodule
